// ===== hdl/alss_pkg.sv =====
// Shared types, constants and helpers for the access-log status and size scanner.
`default_nettype none

package alss_pkg;

   // Payload field widths
   localparam int unsigned CodeWidth  = 16;
   localparam int unsigned SizeWidth  = 32;
   localparam int unsigned CountWidth = 32;
   localparam int unsigned SumWidth   = 48;
   localparam int unsigned IndexWidth = 10;

   // Opcodes of the request channel
   localparam logic OP_DATA = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Kinds of the response channel
   localparam logic KIND_LINE = 1'b0;
   localparam logic KIND_READ = 1'b1;

   // Characters the parser reacts to
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_QUOTE   = 8'h22;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   // Per-line parser phases
   typedef enum logic [2:0] {
      PH_NOQUOTE,
      PH_SKIP1,
      PH_NUM1,
      PH_SKIP2,
      PH_NUM2,
      PH_DONE,
      PH_FAIL
   } phase_type;

   // Saturating increment of a 32-bit counter
   function automatic logic [31:0] sat_inc32(input logic [31:0] value);
      sat_inc32 = (&value) ? value : value + 32'd1;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/alss_if.sv =====
// Request and response channel interfaces of the access-log scanner.
`default_nettype none

interface alss_req_if;
   logic                               valid;
   logic                               ready;
   logic                               opcode;
   logic [7:0]                         data_byte;
   logic [alss_pkg::IndexWidth-1:0]    read_index;

   modport source (output valid, output opcode, output data_byte, output read_index,
                   input ready);
   modport sink   (input valid, input opcode, input data_byte, input read_index,
                   output ready);
endinterface

interface alss_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               result_kind;
   logic                               line_parsed;
   logic [alss_pkg::CodeWidth-1:0]     status_code;
   logic [alss_pkg::SizeWidth-1:0]     response_size;
   logic [alss_pkg::CountWidth-1:0]    code_count;
   logic [alss_pkg::CountWidth-1:0]    lines_total;
   logic [alss_pkg::CountWidth-1:0]    parsed_total;
   logic [alss_pkg::SizeWidth-1:0]     size_min;
   logic [alss_pkg::SizeWidth-1:0]     size_max;
   logic [alss_pkg::SumWidth-1:0]      size_sum;

   modport source (output valid, output result_kind, output line_parsed,
                   output status_code, output response_size, output code_count,
                   output lines_total, output parsed_total, output size_min,
                   output size_max, output size_sum, input ready);
   modport sink   (input valid, input result_kind, input line_parsed,
                   input status_code, input response_size, input code_count,
                   input lines_total, input parsed_total, input size_min,
                   input size_max, input size_sum, output ready);
endinterface

`default_nettype wire

// ===== hdl/access_log_status_size_scanner.sv =====
// Access-log scanner: per-line status/size parser, code histogram and size statistics.
//
// Usage:
//   req_chan carries one transfer per log byte (opcode data) or per histogram
//   read (opcode read, read_index selects the status code). Bytes other than a
//   newline give no response; a newline gives one line result and a read gives
//   one read result on rsp_chan, both with the running line and size totals.
//   Throughput is one request per clock while the receiver keeps up and no
//   clearing sweep runs. A request transfer reads the histogram memory into the
//   middle stage; when that stage advances, the saturating increment is loaded
//   into the output register, which drives the response on rsp_chan.
//   The histogram lives in a CODE_LIMIT-entry memory with one read and one write
//   port; back-to-back lines with the same code forward the pending write.
//   After reset the block sweeps the histogram to zero, one entry per clock,
//   so req_chan.ready stays low until the CODE_LIMIT entries (600 by default) are zero.
//   When the receiver stalls, the output register holds its response, the
//   middle stage holds one more, and req_chan.ready drops once both are full.
//   Plain data bytes also flow only while the middle stage is empty or can advance.
`default_nettype none

module access_log_status_size_scanner #(
   parameter int unsigned CODE_LIMIT = 600
) (
   input  wire          clock,
   input  wire          reset,
   alss_req_if.sink     req_chan,
   alss_rsp_if.source   rsp_chan
);

   localparam int unsigned AW = (CODE_LIMIT > 1) ? $clog2(CODE_LIMIT) : 1;
   localparam logic [alss_pkg::CodeWidth-1:0] LimitCode = alss_pkg::CodeWidth'(CODE_LIMIT);
   localparam logic [AW-1:0] LastAddr = AW'(CODE_LIMIT - 1);

   // Histogram memory and its read data
   logic [alss_pkg::CountWidth-1:0] hist_mem [CODE_LIMIT];
   logic [alss_pkg::CountWidth-1:0] mem_q_ff;

   // Clearing sweep
   logic          clear_ff, clear_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   // Parser state
   alss_pkg::phase_type               phase_ff, phase_in;
   logic [alss_pkg::CodeWidth-1:0]    first_ff, first_in;
   logic [alss_pkg::SizeWidth-1:0]    second_ff, second_in;

   // Running statistics
   logic [alss_pkg::CountWidth-1:0]   lines_ff, lines_in;
   logic [alss_pkg::CountWidth-1:0]   parsed_ff, parsed_in;
   logic [alss_pkg::SizeWidth-1:0]    min_ff, min_in;
   logic [alss_pkg::SizeWidth-1:0]    max_ff, max_in;
   logic [alss_pkg::SumWidth-1:0]     sum_ff, sum_in;

   // Middle stage
   logic                              s1_valid_ff, s1_valid_in;
   logic                              s1_kind_ff;
   logic                              s1_parsed_ff;
   logic [alss_pkg::CodeWidth-1:0]    s1_code_ff;
   logic [alss_pkg::SizeWidth-1:0]    s1_size_ff;
   logic                              s1_hit_ff;
   logic                              s1_inc_ff;
   logic [AW-1:0]                     s1_idx_ff;
   logic [alss_pkg::CountWidth-1:0]   s1_lines_ff, s1_parsed_tot_ff;
   logic [alss_pkg::SizeWidth-1:0]    s1_min_ff, s1_max_ff;
   logic [alss_pkg::SumWidth-1:0]     s1_sum_ff;
   logic                              fwd_hit_ff;
   logic [alss_pkg::CountWidth-1:0]   fwd_data_ff;

   // Output register
   logic                              out_valid_ff, out_valid_in;
   logic                              out_kind_ff;
   logic                              out_parsed_ff;
   logic [alss_pkg::CodeWidth-1:0]    out_code_ff;
   logic [alss_pkg::SizeWidth-1:0]    out_size_ff;
   logic [alss_pkg::CountWidth-1:0]   out_count_ff;
   logic [alss_pkg::CountWidth-1:0]   out_lines_ff, out_parsed_tot_ff;
   logic [alss_pkg::SizeWidth-1:0]    out_min_ff, out_max_ff;
   logic [alss_pkg::SumWidth-1:0]     out_sum_ff;

   // Combinational helpers
   logic                              req_fire;
   logic                              s1_adv;
   logic                              is_newline, is_quote, is_digit, is_space;
   logic [3:0]                        digit;
   logic [19:0]                       acc16;
   logic [35:0]                       acc32;
   logic                              line_ok;
   logic                              is_result;
   logic [alss_pkg::CodeWidth-1:0]    key;
   logic                              key_in_range;
   logic                              rd_hit;
   logic                              rd_inc;
   logic [AW-1:0]                     rd_idx;
   logic [alss_pkg::SumWidth:0]       sum_wide;
   logic [alss_pkg::CountWidth-1:0]   base_cnt, new_cnt, s1_count;

   // Handshake
   assign s1_adv   = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !clear_ff && (!s1_valid_ff || s1_adv);
   assign req_fire = req_chan.valid && req_chan.ready;

   // Classify the byte
   assign is_newline = (req_chan.data_byte == alss_pkg::CHAR_NEWLINE);
   assign is_quote   = (req_chan.data_byte == alss_pkg::CHAR_QUOTE);
   assign is_space   = (req_chan.data_byte == alss_pkg::CHAR_SPACE);
   assign is_digit   = (req_chan.data_byte >= alss_pkg::CHAR_ZERO) &&
                       (req_chan.data_byte <= alss_pkg::CHAR_NINE);
   assign digit      = req_chan.data_byte[3:0];

   // Decimal accumulate, ten times plus digit
   assign acc16 = ({4'd0, first_ff} << 3) + ({4'd0, first_ff} << 1) + {16'd0, digit};
   assign acc32 = ({4'd0, second_ff} << 3) + ({4'd0, second_ff} << 1) + {32'd0, digit};

   assign line_ok = (phase_ff == alss_pkg::PH_NUM2) || (phase_ff == alss_pkg::PH_DONE);

   // Next parser state
   always_comb begin
      phase_in  = phase_ff;
      first_in  = first_ff;
      second_in = second_ff;
      if (req_fire && (req_chan.opcode == alss_pkg::OP_DATA)) begin
         if (is_newline) begin
            phase_in  = alss_pkg::PH_NOQUOTE;
            first_in  = '0;
            second_in = '0;
         end else if (is_quote) begin
            phase_in  = alss_pkg::PH_SKIP1;
            first_in  = '0;
            second_in = '0;
         end else begin
            case (phase_ff)
               alss_pkg::PH_SKIP1: begin
                  if (is_digit) begin
                     first_in = {12'd0, digit};
                     phase_in = alss_pkg::PH_NUM1;
                  end else if (!is_space) begin
                     phase_in = alss_pkg::PH_FAIL;
                  end
               end
               alss_pkg::PH_NUM1: begin
                  if (is_digit) begin
                     first_in = (acc16 > 20'h0ffff) ? '1 : acc16[15:0];
                  end else begin
                     phase_in = is_space ? alss_pkg::PH_SKIP2 : alss_pkg::PH_FAIL;
                  end
               end
               alss_pkg::PH_SKIP2: begin
                  if (is_digit) begin
                     second_in = {28'd0, digit};
                     phase_in  = alss_pkg::PH_NUM2;
                  end else if (!is_space) begin
                     phase_in = alss_pkg::PH_FAIL;
                  end
               end
               alss_pkg::PH_NUM2: begin
                  if (is_digit) begin
                     second_in = (acc32 > 36'h0ffffffff) ? '1 : acc32[31:0];
                  end else begin
                     phase_in = alss_pkg::PH_DONE;
                  end
               end
               alss_pkg::PH_NOQUOTE, alss_pkg::PH_DONE, alss_pkg::PH_FAIL: begin
                  phase_in = phase_ff;
               end
               default: begin
                  phase_in = alss_pkg::PH_FAIL;
               end
            endcase
         end
      end
   end

   // Parser state register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= alss_pkg::PH_NOQUOTE;
         first_ff  <= '0;
         second_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   // Update line totals and size statistics at a newline
   assign sum_wide = {1'b0, sum_ff} + {17'd0, second_ff};

   always_comb begin
      lines_in  = lines_ff;
      parsed_in = parsed_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      sum_in    = sum_ff;
      if (req_fire && (req_chan.opcode == alss_pkg::OP_DATA) && is_newline) begin
         lines_in = alss_pkg::sat_inc32(lines_ff);
         if (line_ok) begin
            parsed_in = alss_pkg::sat_inc32(parsed_ff);
            min_in    = (second_ff < min_ff) ? second_ff : min_ff;
            max_in    = (second_ff > max_ff) ? second_ff : max_ff;
            sum_in    = sum_wide[alss_pkg::SumWidth] ? '1 : sum_wide[alss_pkg::SumWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lines_ff  <= '0;
         parsed_ff <= '0;
         min_ff    <= '1;
         max_ff    <= '0;
         sum_ff    <= '0;
      end else begin
         lines_ff  <= lines_in;
         parsed_ff <= parsed_in;
         min_ff    <= min_in;
         max_ff    <= max_in;
         sum_ff    <= sum_in;
      end
   end

   // Select the histogram entry a result transfer touches
   assign is_result    = req_fire && ((req_chan.opcode == alss_pkg::OP_READ) || is_newline);
   assign key          = (req_chan.opcode == alss_pkg::OP_READ) ?
                         alss_pkg::CodeWidth'(req_chan.read_index) : first_ff;
   assign key_in_range = (key < LimitCode);
   assign rd_hit       = key_in_range &&
                         ((req_chan.opcode == alss_pkg::OP_READ) || line_ok);
   assign rd_inc       = key_in_range && (req_chan.opcode == alss_pkg::OP_DATA) && line_ok;
   assign rd_idx       = key[AW-1:0];

   // Count after update, with forwarding of the write issued at the read edge
   assign base_cnt = fwd_hit_ff ? fwd_data_ff : mem_q_ff;
   assign new_cnt  = s1_inc_ff ? alss_pkg::sat_inc32(base_cnt) : base_cnt;
   assign s1_count = s1_hit_ff ? new_cnt : '0;

   // Clearing sweep control
   always_comb begin
      clear_in    = clear_ff;
      clr_addr_in = clr_addr_ff;
      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == LastAddr) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clear_ff    <= clear_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Histogram memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (clear_ff) begin
         hist_mem[clr_addr_ff] <= '0;
      end else if (s1_adv && s1_inc_ff) begin
         hist_mem[s1_idx_ff] <= new_cnt;
      end
      if (is_result && rd_hit) begin
         mem_q_ff <= hist_mem[rd_idx];
      end
   end

   // Middle stage valid
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (is_result) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Capture the result transfer into the middle stage
   always_ff @(posedge clock) begin
      if (is_result) begin
         s1_kind_ff       <= (req_chan.opcode == alss_pkg::OP_READ) ?
                             alss_pkg::KIND_READ : alss_pkg::KIND_LINE;
         s1_parsed_ff     <= (req_chan.opcode == alss_pkg::OP_DATA) && line_ok;
         s1_code_ff       <= ((req_chan.opcode == alss_pkg::OP_READ) || line_ok) ? key : '0;
         s1_size_ff       <= ((req_chan.opcode == alss_pkg::OP_DATA) && line_ok) ?
                             second_ff : '0;
         s1_hit_ff        <= rd_hit;
         s1_inc_ff        <= rd_inc;
         s1_idx_ff        <= rd_idx;
         s1_lines_ff      <= lines_in;
         s1_parsed_tot_ff <= parsed_in;
         s1_min_ff        <= min_in;
         s1_max_ff        <= max_in;
         s1_sum_ff        <= sum_in;
         fwd_hit_ff       <= s1_adv && s1_inc_ff && (s1_idx_ff == rd_idx);
         fwd_data_ff      <= new_cnt;
      end
   end

   // Output register valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Advance the middle stage into the output register
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_kind_ff       <= s1_kind_ff;
         out_parsed_ff     <= s1_parsed_ff;
         out_code_ff       <= s1_code_ff;
         out_size_ff       <= s1_size_ff;
         out_count_ff      <= s1_count;
         out_lines_ff      <= s1_lines_ff;
         out_parsed_tot_ff <= s1_parsed_tot_ff;
         out_min_ff        <= s1_min_ff;
         out_max_ff        <= s1_max_ff;
         out_sum_ff        <= s1_sum_ff;
      end
   end

   // Drive the response channel
   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.result_kind   = out_kind_ff;
   assign rsp_chan.line_parsed   = out_parsed_ff;
   assign rsp_chan.status_code   = out_code_ff;
   assign rsp_chan.response_size = out_size_ff;
   assign rsp_chan.code_count    = out_count_ff;
   assign rsp_chan.lines_total   = out_lines_ff;
   assign rsp_chan.parsed_total  = out_parsed_tot_ff;
   assign rsp_chan.size_min      = out_min_ff;
   assign rsp_chan.size_max      = out_max_ff;
   assign rsp_chan.size_sum      = out_sum_ff;

   // No request transfer while the histogram is being swept
   a_no_transfer_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !req_fire)
      else $error("request transfer during histogram clear");

   // Parsed lines never outnumber lines
   a_parsed_le_lines: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (parsed_ff <= lines_ff))
      else $error("parsed line count exceeds line count");

   // Size minimum never grows, maximum never shrinks
   a_min_max_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((min_ff <= $past(min_ff)) && (max_ff >= $past(max_ff))))
      else $error("size minimum or maximum moved the wrong way");

   // A middle stage that cannot advance blocks new requests
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request accepted while the pipeline is full");

endmodule

`default_nettype wire

// ===== tb/sv/tb_access_log_status_size_scanner.sv =====
// Testbench for the access-log status and size scanner: byte-stream stimulus and report checking.
`timescale 1ns / 1ps

module tb_access_log_status_size_scanner;

   localparam int unsigned CodeLimit   = 600;
   localparam int unsigned RandomItems = 1650;
   localparam int unsigned TotalItems  = 1800;

   // One report as the scanner should return it
   typedef struct packed {
      logic        kind;
      logic        parsed;
      logic [15:0] code;
      logic [31:0] size;
      logic [31:0] count;
      logic [31:0] line_count;
      logic [31:0] parse_count;
      logic [31:0] size_lo;
      logic [31:0] size_hi;
      logic [47:0] size_total;
   } scan_report_type;

   logic clock;
   logic reset;

   alss_req_if req_bus ();
   alss_rsp_if rsp_bus ();

   access_log_status_size_scanner #(
      .CODE_LIMIT(CodeLimit)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   // Predicted scanner state
   alss_pkg::phase_type scan_phase = alss_pkg::PH_NOQUOTE;
   logic [15:0] code_acc = '0;
   logic [31:0] size_acc = '0;
   logic [31:0] code_hist [CodeLimit];
   logic [31:0] seen_lines = '0;
   logic [31:0] good_lines = '0;
   logic [31:0] least_size = '1;
   logic [31:0] most_size = '0;
   logic [47:0] size_sum_acc = '0;

   scan_report_type awaited_reports[$];
   logic [7:0]   line_buf[$];

   int unsigned  mismatch_count = 0;
   int unsigned  items_sent = 0;
   bit           quiet_tail = 1'b0;

   int unsigned  common_codes[10] = '{200, 204, 206, 301, 302, 304, 400, 403, 404, 500};

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic [31:0] bump_count(input logic [31:0] value);
      return (&value) ? value : value + 32'd1;
   endfunction

   function automatic logic [63:0] append_digit(input logic [63:0] acc, input logic [3:0] digit,
                                                input logic [63:0] cap);
      logic [63:0] r;
      r = acc * 64'd10 + 64'(digit);
      return (r > cap) ? cap : r;
   endfunction

   // Advance the predicted state by one request; return 1 when a report is due
   function automatic bit compute_report(input logic op, input logic [7:0] ch,
                                         input logic [9:0] idx, output scan_report_type rep);
      logic        is_digit;
      logic [3:0]  dval;
      logic [63:0] wide;
      bit          has_report;
      rep = '0;
      has_report = 1'b0;
      if (op == alss_pkg::OP_READ) begin
         rep.kind = alss_pkg::KIND_READ;
         rep.code = 16'(idx);
         rep.count = (idx < CodeLimit) ? code_hist[idx] : '0;
         has_report = 1'b1;
      end else if (ch == alss_pkg::CHAR_NEWLINE) begin
         rep.kind = alss_pkg::KIND_LINE;
         seen_lines = bump_count(seen_lines);
         if (scan_phase == alss_pkg::PH_NUM2 || scan_phase == alss_pkg::PH_DONE) begin
            good_lines = bump_count(good_lines);
            if (size_acc < least_size) least_size = size_acc;
            if (size_acc > most_size) most_size = size_acc;
            wide = {16'b0, size_sum_acc} + {32'b0, size_acc};
            size_sum_acc = (wide > 64'hFFFF_FFFF_FFFF) ? '1 : wide[47:0];
            rep.parsed = 1'b1;
            rep.code = code_acc;
            rep.size = size_acc;
            if (code_acc < CodeLimit) begin
               code_hist[code_acc] = bump_count(code_hist[code_acc]);
               rep.count = code_hist[code_acc];
            end
         end
         scan_phase = alss_pkg::PH_NOQUOTE;
         code_acc = '0;
         size_acc = '0;
         has_report = 1'b1;
      end else if (ch == alss_pkg::CHAR_QUOTE) begin
         // A quote restarts the parse
         scan_phase = alss_pkg::PH_SKIP1;
         code_acc = '0;
         size_acc = '0;
      end else begin
         is_digit = (ch >= alss_pkg::CHAR_ZERO) && (ch <= alss_pkg::CHAR_NINE);
         dval = ch[3:0];
         case (scan_phase)
            alss_pkg::PH_SKIP1: begin
               if (is_digit) begin
                  code_acc = 16'(dval);
                  scan_phase = alss_pkg::PH_NUM1;
               end else if (ch != alss_pkg::CHAR_SPACE) begin
                  scan_phase = alss_pkg::PH_FAIL;
               end
            end
            alss_pkg::PH_NUM1: begin
               if (is_digit) code_acc = 16'(append_digit(64'(code_acc), dval, 64'hFFFF));
               else scan_phase = (ch == alss_pkg::CHAR_SPACE) ? alss_pkg::PH_SKIP2 :
                                                                alss_pkg::PH_FAIL;
            end
            alss_pkg::PH_SKIP2: begin
               if (is_digit) begin
                  size_acc = 32'(dval);
                  scan_phase = alss_pkg::PH_NUM2;
               end else if (ch != alss_pkg::CHAR_SPACE) begin
                  scan_phase = alss_pkg::PH_FAIL;
               end
            end
            alss_pkg::PH_NUM2: begin
               if (is_digit) size_acc = 32'(append_digit(64'(size_acc), dval, 64'hFFFF_FFFF));
               else scan_phase = alss_pkg::PH_DONE;
            end
            default: ;
         endcase
      end
      if (has_report) begin
         rep.line_count = seen_lines;
         rep.parse_count = good_lines;
         rep.size_lo = least_size;
         rep.size_hi = most_size;
         rep.size_total = size_sum_acc;
      end
      return has_report;
   endfunction

   // Drive one request, hold it until the transfer, then predict its report
   task automatic send_request(input logic op, input logic [7:0] ch, input logic [9:0] idx);
      scan_report_type rep;
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= op;
      req_bus.data_byte <= ch;
      req_bus.read_index <= idx;
      do @(posedge clock); while (!req_bus.ready);
      if (compute_report(op, ch, idx, rep)) awaited_reports.push_back(rep);
      items_sent++;
   endtask

   function automatic logic [9:0] pick_index();
      case ($urandom_range(0, 2))
         0:       return 10'(common_codes[$urandom_range(0, 9)]);
         1:       return 10'($urandom_range(0, CodeLimit - 1));
         default: return 10'($urandom_range(0, 1023));
      endcase
   endfunction

   function automatic void put_text(input string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endfunction

   // Random byte that neither restarts nor ends the line
   function automatic logic [7:0] rand_plain(input bit allow_digit, input bit allow_space);
      logic [7:0] ch;
      do ch = 8'($urandom_range(0, 255));
      while (ch == alss_pkg::CHAR_QUOTE || ch == alss_pkg::CHAR_NEWLINE ||
             (!allow_digit && ch >= alss_pkg::CHAR_ZERO && ch <= alss_pkg::CHAR_NINE) ||
             (!allow_space && ch == alss_pkg::CHAR_SPACE));
      return ch;
   endfunction

   function automatic void put_junk(input int unsigned n);
      repeat (n) line_buf.push_back(rand_plain(1'b1, 1'b1));
   endfunction

   function automatic void put_spaces(input int unsigned n);
      repeat (n) line_buf.push_back(alss_pkg::CHAR_SPACE);
   endfunction

   // Status code text: common and in-range codes, limit crossers, saturating and zero-padded forms
   function automatic void put_code();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: put_text($sformatf("%0d", common_codes[$urandom_range(0, 9)]));
         6: put_text($sformatf("%0d", $urandom_range(0, CodeLimit - 1)));
         7: put_text($sformatf("%0d", $urandom_range(CodeLimit, 65535)));
         8: put_text($sformatf("%0d", $urandom_range(65536, 99999999)));
         default: put_text($sformatf("00%0d", common_codes[$urandom_range(0, 9)]));
      endcase
   endfunction

   // Size text: small, zero, full 32-bit, exact maximum, saturating and zero-padded
   function automatic void put_size();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: put_text($sformatf("%0d", $urandom_range(0, 99999)));
         5: put_text("0");
         6: put_text($sformatf("%0d", $urandom));
         7: put_text("4294967295");
         8: put_text($sformatf("%0d%06d", $urandom_range(42950, 999999),
                               $urandom_range(0, 999999)));
         default: put_text($sformatf("000%0d", $urandom_range(0, 9999)));
      endcase
   endfunction

   // Send the buffered line, with a histogram read slipped in now and then
   task automatic flush_line();
      foreach (line_buf[i]) begin
         if ($urandom_range(0, 39) == 0) begin
            send_request(alss_pkg::OP_READ, 8'($urandom), pick_index());
         end
         send_request(alss_pkg::OP_DATA, line_buf[i], 10'($urandom));
      end
      line_buf.delete();
   endtask

   task automatic test_minimal_line();
      put_text("\"0 0\n");
      flush_line();
   endtask

   task automatic test_unquoted_line();
      line_buf.push_back(alss_pkg::CHAR_NEWLINE);
      flush_line();
   endtask

   task automatic test_other_bytes();
      // NUL right after the quote fails the parse
      line_buf.push_back(alss_pkg::CHAR_QUOTE);
      line_buf.push_back(8'h00);
      line_buf.push_back(8'hFF);
      line_buf.push_back(alss_pkg::CHAR_NEWLINE);
      flush_line();
   endtask

   task automatic test_code_limit();
      put_text("\"600 9\n");
      flush_line();
   endtask

   task automatic test_reads();
      send_request(alss_pkg::OP_READ, 8'hFF, 10'd0);
      send_request(alss_pkg::OP_READ, 8'h00, 10'(CodeLimit - 1));
      send_request(alss_pkg::OP_READ, 8'hFF, 10'(CodeLimit));
      send_request(alss_pkg::OP_READ, 8'h00, 10'h3FF);
   endtask

   task automatic test_random_traffic();
      int unsigned pick;
      while (items_sent < RandomItems) begin
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            // Well-formed: prefix, quoted request, code, size, optional tail
            put_junk($urandom_range(0, 6));
            line_buf.push_back(alss_pkg::CHAR_QUOTE);
            put_junk($urandom_range(0, 8));
            line_buf.push_back(alss_pkg::CHAR_QUOTE);
            put_spaces($urandom_range(0, 2));
            put_code();
            put_spaces($urandom_range(1, 3));
            put_size();
            if ($urandom_range(0, 2) == 0) begin
               line_buf.push_back(rand_plain(1'b0, 1'b1));
               put_junk($urandom_range(0, 5));
            end
            line_buf.push_back(alss_pkg::CHAR_NEWLINE);
         end else if (pick < 18) begin
            // Broken lines
            case ($urandom_range(0, 5))
               0: put_junk($urandom_range(0, 10));
               1: begin
                  line_buf.push_back(alss_pkg::CHAR_QUOTE);
                  put_code();
                  put_spaces($urandom_range(0, 2));
               end
               2: begin
                  line_buf.push_back(alss_pkg::CHAR_QUOTE);
                  put_code();
                  line_buf.push_back(rand_plain(1'b0, 1'b0));
                  put_size();
               end
               3: begin
                  line_buf.push_back(alss_pkg::CHAR_QUOTE);
                  line_buf.push_back(rand_plain(1'b0, 1'b0));
                  put_code();
                  put_spaces(1);
                  put_size();
               end
               4: begin
                  // A late quote restarts the parse, maybe with a fresh code and size
                  line_buf.push_back(alss_pkg::CHAR_QUOTE);
                  put_code();
                  put_spaces(1);
                  put_size();
                  put_spaces($urandom_range(0, 1));
                  line_buf.push_back(alss_pkg::CHAR_QUOTE);
                  if ($urandom_range(0, 1) == 0) begin
                     put_code();
                     put_spaces(1);
                     put_size();
                  end
               end
               default: begin
                  if ($urandom_range(0, 1) == 0) line_buf.push_back(alss_pkg::CHAR_QUOTE);
               end
            endcase
            line_buf.push_back(alss_pkg::CHAR_NEWLINE);
         end else begin
            // Raw noise, any byte value
            repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
            line_buf.push_back(alss_pkg::CHAR_NEWLINE);
         end
         flush_line();
      end
   endtask

   task automatic test_back_to_back();
      int unsigned code_val;
      quiet_tail = 1'b1;
      // Repeat a few codes closely so histogram updates and reads collide
      while (items_sent < TotalItems) begin
         code_val = common_codes[$urandom_range(0, 2)];
         line_buf.push_back(alss_pkg::CHAR_QUOTE);
         put_text($sformatf("%0d %0d", code_val, $urandom_range(0, 999)));
         line_buf.push_back(alss_pkg::CHAR_NEWLINE);
         flush_line();
         send_request(alss_pkg::OP_READ, 8'($urandom), 10'(code_val));
      end
   endtask

   function automatic void check_field(input string field, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   // Compare every response transfer with the oldest awaited report
   always @(posedge clock) begin : report_check
      scan_report_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_reports.size() == 0) begin
            $display("%0t ns: unexpected response, expected none, actual kind %0d code %0d",
                     $time, rsp_bus.result_kind, rsp_bus.status_code);
            mismatch_count++;
         end else begin
            want = awaited_reports.pop_front();
            check_field("result_kind", 64'(want.kind), 64'(rsp_bus.result_kind));
            check_field("line_parsed", 64'(want.parsed), 64'(rsp_bus.line_parsed));
            check_field("status_code", 64'(want.code), 64'(rsp_bus.status_code));
            check_field("response_size", 64'(want.size), 64'(rsp_bus.response_size));
            check_field("code_count", 64'(want.count), 64'(rsp_bus.code_count));
            check_field("lines_total", 64'(want.line_count), 64'(rsp_bus.lines_total));
            check_field("parsed_total", 64'(want.parse_count), 64'(rsp_bus.parsed_total));
            check_field("size_min", 64'(want.size_lo), 64'(rsp_bus.size_min));
            check_field("size_max", 64'(want.size_hi), 64'(rsp_bus.size_max));
            check_field("size_sum", 64'(want.size_total), 64'(rsp_bus.size_sum));
         end
      end
   end

   // Receiver stalls in random bursts; none in the tail
   initial begin : rsp_ready_driver
      int unsigned stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left != 0) stall_left--;
         else if (!quiet_tail && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 9);
         rsp_bus.ready <= (stall_left == 0);
      end
   end

   // Stimulus sequence
   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.opcode <= alss_pkg::OP_DATA;
      req_bus.data_byte <= '0;
      req_bus.read_index <= '0;
      foreach (code_hist[i]) code_hist[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_minimal_line();
      test_unquoted_line();
      test_other_bytes();
      test_code_limit();
      test_reads();
      test_random_traffic();
      test_back_to_back();

      // Drain outstanding reports
      req_bus.valid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_access_log_status_size_scanner OK");
      end else begin
         $display("tb_access_log_status_size_scanner NOT OK");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("tb_access_log_status_size_scanner NOT OK");
      $finish;
   end

endmodule
